/* rtl/stsq_pkg.sv */
// stsq_pkg: shared constants for the stimulation train sequencer.
// Request codes, register indexes, beat layouts and default sizes.
// No dependencies.
package stsq_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_TRIGGER = 2'd1;
	localparam logic [1:0] REQ_STEP    = 2'd2;

	// configuration register indexes
	localparam logic [0:0] CFG_SEQUENCE_REPEATS = 1'b0;
	localparam logic [0:0] CFG_ELEMENT_COUNT    = 1'b1;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	// beat widths; the data widths are padded to whole bytes
	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;

	// pattern ids carried by a load beat
	localparam int INPUT_IDS = 6;

	// start of a pattern pair relative to the step time stamp
	localparam logic [31:0] START_DELAY = 32'd100;

	localparam int DEFAULT_TABLE_DEPTH   = 128;
	localparam int DEFAULT_PATTERN_SLOTS = 6;

endpackage

/* rtl/stim_train_sequencer.sv */
// stim_train_sequencer: nested-repeat stimulation sequencer, top level.
// Element table memory, step counters, input stage and result register.
// Depends on stsq_pkg.
// Usage: input beats on s_tvalid/s_tready/s_tdata carry the request kind on
//   s_tuser: load an element into the table, trigger (clear the counters and
//   load the enable from the beat), or step. Every step beat yields exactly one result beat
//   on m_tvalid/m_tready/m_tdata; load, trigger and the unused request code
//   yield none. Write the registers (sequence repeats, element count) through
//   cfg_we/cfg_addr/cfg_wdata only while the block is idle.
// Timing: a beat lands in the input stage at acceptance and is processed in
//   the following cycle; its result is in the output register at the next
//   edge, and that register drives m_tvalid. One beat per cycle is sustained
//   while the output register is free or draining: the current and the following
//   table element sit in two registered read ports, refreshed every cycle from
//   the next counter state, so a step never waits on the table.
// Reset: arst_n clears the counters, the enable, both stages and the registers
//   (sequence repeats 0, element count 1); table contents stay undefined.
// Back-pressure: while m_tready is low a finished result holds in the output
//   register; load, trigger and ignored beats keep flowing, but the next step
//   beat holds in the input stage and s_tready stays low until the result goes.
module stim_train_sequencer #(
	parameter int TABLE_DEPTH   = stsq_pkg::DEFAULT_TABLE_DEPTH,
	parameter int PATTERN_SLOTS = stsq_pkg::DEFAULT_PATTERN_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata, lowest bit up: enable[0], time_now[32:1], element_index[39:33],
	// pattern_count[42:40], element_repeat[50:43], pattern_id_0[58:51],
	// pattern_id_1[66:59], pattern_id_2[74:67], pattern_id_3[82:75],
	// pattern_id_4[90:83], pattern_id_5[98:91], zero pad [103:99]
	input  logic [stsq_pkg::IN_DATA_W-1:0]    s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [stsq_pkg::IN_USER_W-1:0]    s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata, lowest bit up: fired[0], first_pattern[9:1], last_pattern[18:10],
	// start_time[50:19], running[51], zero pad [55:52]
	output logic [stsq_pkg::OUT_DATA_W-1:0]   m_tdata,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [stsq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [stsq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CntW = $clog2(TABLE_DEPTH + 1);
	localparam int PcW  = $clog2(PATTERN_SLOTS + 1);
	localparam int SlW  = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
	localparam int IdsW = 8 * PATTERN_SLOTS;
	// table word: pattern count, element repeat, slot ids
	localparam int EntW = PcW + 8 + IdsW;

	// ---------------------------------------------------------------
	// input stage
	// ---------------------------------------------------------------
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic        enable_s1;
	logic [31:0] time_s1;
	logic [6:0]  index_s1;
	logic [2:0]  pcount_s1;
	logic [7:0]  repeat_s1;
	logic [47:0] ids_s1;
	logic        go_s1;

	// a step may only move on when the output register is free or draining
	assign go_s1    = valid_s1 && ((req_s1 != stsq_pkg::REQ_STEP) || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1    <= s_tuser[1:0];
			enable_s1 <= s_tdata[0];
			time_s1   <= s_tdata[32:1];
			index_s1  <= s_tdata[39:33];
			pcount_s1 <= s_tdata[42:40];
			repeat_s1 <= s_tdata[50:43];
			ids_s1    <= s_tdata[98:51];
		end
	end

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [15:0]     seq_reps_q;
	logic [CntW-1:0] elem_cnt_q;
	logic [CntW-1:0] elem_cnt_d;
	logic [CntW-1:0] cnt_clamped;
	logic [7:0]      cnt_raw;

	assign cnt_raw = cfg_wdata[7:0];

	always_comb begin
		// zero becomes one, above the table depth saturates
		if (cnt_raw == 8'd0) begin
			cnt_clamped = CntW'(1);
		end else if (32'(cnt_raw) > TABLE_DEPTH) begin
			cnt_clamped = CntW'(TABLE_DEPTH);
		end else begin
			cnt_clamped = CntW'(cnt_raw);
		end
		elem_cnt_d = elem_cnt_q;
		if (cfg_we && cfg_addr == stsq_pkg::CFG_ELEMENT_COUNT) begin
			elem_cnt_d = cnt_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_reps_q <= '0;
			elem_cnt_q <= CntW'(1);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				stsq_pkg::CFG_SEQUENCE_REPEATS: seq_reps_q <= cfg_wdata;
				stsq_pkg::CFG_ELEMENT_COUNT:    elem_cnt_q <= cnt_clamped;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// element table: one write port, two registered read ports
	// ---------------------------------------------------------------
	logic [EntW-1:0] table_mem [TABLE_DEPTH];
	logic [EntW-1:0] rd_a_q;      // current element
	logic [EntW-1:0] rd_b_q;      // element that follows it
	logic            mem_we;
	logic [IdxW-1:0] mem_waddr;
	logic [EntW-1:0] mem_wdata;
	logic [IdxW-1:0] raddr_a;
	logic [IdxW-1:0] raddr_b;
	logic [PcW-1:0]  pc_clamped;

	always_comb begin
		if (pcount_s1 == 3'd0) begin
			pc_clamped = PcW'(1);
		end else if (32'(pcount_s1) > PATTERN_SLOTS) begin
			pc_clamped = PcW'(PATTERN_SLOTS);
		end else begin
			pc_clamped = PcW'(pcount_s1);
		end
	end

	// drop loads beyond the table; ids past the slot count fall away,
	// slots past the carried ids read as none
	assign mem_we    = go_s1 && (req_s1 == stsq_pkg::REQ_LOAD) && (32'(index_s1) < TABLE_DEPTH);
	assign mem_waddr = IdxW'(index_s1);
	assign mem_wdata = {IdsW'(ids_s1), repeat_s1, pc_clamped};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		// forward a load that hits either read address in the same cycle
		rd_a_q <= (mem_we && mem_waddr == raddr_a) ? mem_wdata : table_mem[raddr_a];
		rd_b_q <= (mem_we && mem_waddr == raddr_b) ? mem_wdata : table_mem[raddr_b];
	end

	// ---------------------------------------------------------------
	// sequencing counters and step logic
	// ---------------------------------------------------------------
	logic [PcW-1:0]  slot_q,  slot_d;
	logic [7:0]      erd_q,   erd_d;
	logic [IdxW-1:0] elem_q,  elem_d;
	logic [15:0]     srd_q,   srd_d;
	logic            en_q,    en_d;

	logic [PcW-1:0]  cur_pc;
	logic [7:0]      cur_rep;
	logic [8:0]      erd_sum;
	logic            elem_wrap;
	logic [IdxW-1:0] elem_nx;
	logic            use_b;
	logic [EntW-1:0] sel_ent;
	logic [7:0]      sel_ids [PATTERN_SLOTS];
	logic [7:0]      slot_id;
	logic            fire;

	assign cur_pc    = rd_a_q[PcW-1:0];
	assign cur_rep   = rd_a_q[PcW +: 8];
	assign erd_sum   = {1'b0, erd_q} + 9'd1;
	// element wraps on reaching or passing the count in use
	assign elem_wrap = (32'(elem_q) + 32'd1) >= 32'(elem_cnt_q);
	assign elem_nx   = elem_wrap ? '0 : IdxW'(32'(elem_q) + 32'd1);

	always_comb begin
		slot_d  = slot_q;
		erd_d   = erd_q;
		elem_d  = elem_q;
		srd_d   = srd_q;
		en_d    = en_q;
		use_b   = 1'b0;
		fire    = 1'b0;
		slot_id = '0;
		sel_ent = rd_a_q;
		for (int i = 0; i < PATTERN_SLOTS; i++) begin
			sel_ids[i] = '0;
		end
		if (go_s1 && req_s1 == stsq_pkg::REQ_TRIGGER) begin
			slot_d = '0;
			erd_d  = '0;
			elem_d = '0;
			srd_d  = '0;
			en_d   = enable_s1;
		end else if (go_s1 && req_s1 == stsq_pkg::REQ_STEP && en_q) begin
			// advance slot, then element repeat, then element, then sequence
			if (slot_q >= cur_pc) begin
				slot_d = '0;
				if (erd_sum >= {1'b0, cur_rep}) begin
					erd_d  = '0;
					elem_d = elem_nx;
					use_b  = 1'b1;
					if (elem_wrap && srd_q != 16'hFFFF) begin
						srd_d = srd_q + 16'd1;
					end
				end else begin
					erd_d = erd_sum[7:0];
				end
			end
			sel_ent = use_b ? rd_b_q : rd_a_q;
			for (int i = 0; i < PATTERN_SLOTS; i++) begin
				sel_ids[i] = sel_ent[PcW + 8 + 8 * i +: 8];
			end
			if (srd_d < seq_reps_q) begin
				if (32'(slot_d) < PATTERN_SLOTS) begin
					slot_id = sel_ids[slot_d[SlW-1:0]];
				end
				fire   = (slot_id != 8'd0);
				slot_d = slot_d + PcW'(1);
			end else begin
				// sequence used up: disable
				en_d = 1'b0;
			end
		end
	end

	// prefetch the element in use and its successor for the next cycle
	assign raddr_a = elem_d;
	assign raddr_b = ((32'(elem_d) + 32'd1) >= 32'(elem_cnt_d)) ? '0 :
		IdxW'(32'(elem_d) + 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			erd_q  <= '0;
			elem_q <= '0;
			srd_q  <= '0;
			en_q   <= 1'b0;
		end else begin
			slot_q <= slot_d;
			erd_q  <= erd_d;
			elem_q <= elem_d;
			srd_q  <= srd_d;
			en_q   <= en_d;
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	logic                             out_valid_q;
	logic [stsq_pkg::OUT_DATA_W-1:0]  out_data_q;
	logic                             step_go;
	logic [8:0]                       first_pat;
	logic [8:0]                       last_pat;
	logic [31:0]                      start_t;

	assign step_go   = go_s1 && (req_s1 == stsq_pkg::REQ_STEP);
	assign first_pat = fire ? {slot_id - 8'd1, 1'b0} : 9'd0;
	assign last_pat  = fire ? {slot_id - 8'd1, 1'b1} : 9'd0;
	assign start_t   = fire ? (time_s1 + stsq_pkg::START_DELAY) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			out_data_q <= {4'd0, en_d, start_t, last_pat, first_pat, fire};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// a pattern pair only ever starts while the sequencer keeps running
	a_fire_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[51])
		else $error("fired result reports sequencer stopped");

	// a trigger with enable low stops the sequencer
	a_trigger_off: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && req_s1 == stsq_pkg::REQ_TRIGGER && !enable_s1 |=> !en_q)
		else $error("trigger with enable low left sequencer running");

	// a step held back by a full output register stays in the input stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go_s1 |=> valid_s1 && $stable(req_s1) && $stable(time_s1))
		else $error("stalled input stage lost its beat");

endmodule

/* test/tb.sv */
// tb: self-checking testbench for stim_train_sequencer.
// Drives load, trigger and step beats, predicts every result beat and checks it.
// Depends on stsq_pkg and the stim_train_sequencer RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_DEPTH   = stsq_pkg::DEFAULT_TABLE_DEPTH;
	localparam int TBL_SLOTS   = stsq_pkg::DEFAULT_PATTERN_SLOTS;
	// request code the block must ignore
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// cycles to let pass after the last result before touching a register
	localparam int SETTLE_CYCLES = 8;
	// cycles with no beat on either side before the run is abandoned
	localparam int QUIET_LIMIT = 4000;
	// length of the long receiver hold-off
	localparam int HOLD_OFF_CYCLES = 300;

	// input beat, lowest field in bit 0
	typedef struct packed {
		logic [4:0]      pad;
		logic [5:0][7:0] ids;
		logic [7:0]      rpt;
		logic [2:0]      cnt;
		logic [6:0]      idx;
		logic [31:0]     time_now;
		logic            enable;
	} beat_fields_t;

	// result beat, lowest field in bit 0
	typedef struct packed {
		logic [3:0]  pad;
		logic        running;
		logic [31:0] start_time;
		logic [8:0]  last_pattern;
		logic [8:0]  first_pattern;
		logic        fired;
	} start_cmd_t;

	localparam start_cmd_t NO_CMD = '0;

	// one row of the directed table
	typedef struct {
		bit           reg_wr;
		logic [0:0]   reg_idx;
		logic [15:0]  reg_val;
		logic [1:0]   req;
		beat_fields_t f;
		bit           typed;
		start_cmd_t   want;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [stsq_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [stsq_pkg::IN_USER_W-1:0]  s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [stsq_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_we = 1'b0;
	logic [stsq_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [stsq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	stim_train_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predicted sequencer state, kept in step with every accepted beat
	// ------------------------------------------------------------------
	int unsigned tbl_cnt [TBL_DEPTH];
	int unsigned tbl_rpt [TBL_DEPTH];
	logic [7:0]  tbl_id  [TBL_DEPTH][TBL_SLOTS];
	int unsigned slot_pos = 0;
	int unsigned rep_done = 0;
	int unsigned cur_el = 0;
	int unsigned seq_done = 0;
	logic        run_en = 1'b0;
	int unsigned seq_repeats = 0;
	int unsigned elem_count = 1;

	start_cmd_t expected_starts[$];

	int err_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int stall_hold = 0;
	int quiet_cycles = 0;

	function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Apply one accepted beat to the predicted state; returns 1 with the
	// expected result when the beat is a step.
	function automatic bit sequence_next(input logic [1:0] req, input beat_fields_t f,
			output start_cmd_t r);
		int unsigned idv;
		r = NO_CMD;
		case (req)
			stsq_pkg::REQ_LOAD: begin
				tbl_cnt[f.idx] = clamp_count(f.cnt, TBL_SLOTS);
				tbl_rpt[f.idx] = f.rpt;
				for (int i = 0; i < TBL_SLOTS; i++)
					tbl_id[f.idx][i] = (i < stsq_pkg::INPUT_IDS) ? f.ids[i] : 8'd0;
				return 1'b0;
			end
			stsq_pkg::REQ_TRIGGER: begin
				slot_pos = 0;
				cur_el = 0;
				rep_done = 0;
				seq_done = 0;
				run_en = f.enable;
				return 1'b0;
			end
			stsq_pkg::REQ_STEP: begin
				if (run_en) begin
					// slot exhausted: roll over into the repeat, element, sequence counters
					if (slot_pos >= tbl_cnt[cur_el]) begin
						slot_pos = 0;
						rep_done++;
						if (rep_done >= tbl_rpt[cur_el]) begin
							rep_done = 0;
							cur_el++;
							if (cur_el >= elem_count) begin
								cur_el = 0;
								if (seq_done < 32'hFFFF)
									seq_done++;
							end
						end
					end
					if (seq_done < seq_repeats) begin
						idv = (slot_pos < TBL_SLOTS) ? tbl_id[cur_el][slot_pos] : 0;
						if (idv != 0) begin
							r.fired         = 1'b1;
							r.first_pattern = 9'(2 * (idv - 1));
							r.last_pattern  = 9'(2 * idv - 1);
							r.start_time    = f.time_now + stsq_pkg::START_DELAY;
						end
						slot_pos++;
					end else begin
						run_en = 1'b0;
					end
				end
				r.running = run_en;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		err_count++;
		if (err_count <= 40)
			$display("%0t MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offer one beat, with random idle cycles ahead of it, and hold it until
	// taken. Predict at the accepting edge.
	task automatic offer_beat(input logic [1:0] req, input beat_fields_t f,
			input bit typed, input start_cmd_t want);
		start_cmd_t pred;
		bit makes;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= f;
		do
			@(posedge clk);
		while (!s_tready);
		makes = sequence_next(req, f, pred);
		if (makes)
			expected_starts.push_back(typed ? want : pred);
	endtask

	// Drop valid, wait for every outstanding result, then let the pipe settle.
	task automatic drain_and_pause();
		s_tvalid <= 1'b0;
		while (expected_starts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == stsq_pkg::CFG_SEQUENCE_REPEATS)
			seq_repeats = val;
		else
			elem_count = clamp_count(val[7:0], TBL_DEPTH);
		@(posedge clk);
	endtask

	function automatic beat_fields_t rand_fields();
		beat_fields_t f;
		f          = '0;
		f.enable   = 1'($urandom_range(0, 1));
		f.time_now = $urandom();
		// now and then sit around the point where the start time wraps
		if ($urandom_range(0, 15) == 0)
			f.time_now = 32'hFFFF_FF9C + $urandom_range(0, 199) - 100;
		f.idx      = 7'($urandom());
		f.cnt      = 3'($urandom());
		f.rpt      = 8'($urandom());
		f.ids      = 48'({$urandom(), $urandom()});
		return f;
	endfunction

	// Bias an element towards short repeats and a fair share of empty slots,
	// so that the step walk moves through many elements.
	function automatic beat_fields_t shape_element(input beat_fields_t f);
		if ($urandom_range(0, 7) != 0)
			f.rpt = 8'($urandom_range(0, 3));
		for (int i = 0; i < stsq_pkg::INPUT_IDS; i++)
			if ($urandom_range(0, 3) == 0)
				f.ids[i] = 8'd0;
		return f;
	endfunction

	task automatic run_random(input int count);
		int done;
		int pick;
		int burst;
		beat_fields_t f;
		done = 0;
		while (done < count) begin
			f    = rand_fields();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				f.enable = ($urandom_range(0, 7) != 0);
				offer_beat(stsq_pkg::REQ_TRIGGER, f, 1'b0, NO_CMD);
				done++;
			end else if (pick < 16) begin
				offer_beat(stsq_pkg::REQ_LOAD, shape_element(f), 1'b0, NO_CMD);
				done++;
			end else if (pick < 19) begin
				// noise: ignored by the block, not counted
				offer_beat(REQ_UNUSED, f, 1'b0, NO_CMD);
			end else begin
				burst = $urandom_range(1, 24);
				repeat (burst) begin
					f = rand_fields();
					offer_beat(stsq_pkg::REQ_STEP, f, 1'b0, NO_CMD);
				end
				done += burst;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Directed table rows
	// ------------------------------------------------------------------
	function automatic dir_row_t row_beat(input logic [1:0] req, input beat_fields_t f);
		dir_row_t r;
		r.reg_wr  = 1'b0;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.req     = req;
		r.f       = f;
		r.typed   = 1'b0;
		r.want    = NO_CMD;
		return r;
	endfunction

	function automatic dir_row_t row_reg(input logic [0:0] idx, input logic [15:0] val);
		dir_row_t r;
		r         = row_beat(REQ_UNUSED, '0);
		r.reg_wr  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic dir_row_t row_load(input logic [6:0] idx, input logic [2:0] cnt,
			input logic [7:0] rpt, input logic [7:0] i0, input logic [7:0] i1,
			input logic [7:0] i2, input logic [7:0] i3, input logic [7:0] i4,
			input logic [7:0] i5);
		beat_fields_t f;
		f     = '0;
		f.idx = idx;
		f.cnt = cnt;
		f.rpt = rpt;
		f.ids = {i5, i4, i3, i2, i1, i0};
		return row_beat(stsq_pkg::REQ_LOAD, f);
	endfunction

	function automatic dir_row_t row_trig(input logic en);
		beat_fields_t f;
		f        = '0;
		f.enable = en;
		return row_beat(stsq_pkg::REQ_TRIGGER, f);
	endfunction

	function automatic dir_row_t row_step(input logic [31:0] t);
		beat_fields_t f;
		f          = '0;
		f.time_now = t;
		return row_beat(stsq_pkg::REQ_STEP, f);
	endfunction

	// step whose result is typed in
	function automatic dir_row_t row_chk(input logic [31:0] t, input logic fired,
			input logic [8:0] first_p, input logic [8:0] last_p, input logic [31:0] st,
			input logic run);
		dir_row_t r;
		r                    = row_step(t);
		r.typed              = 1'b1;
		r.want               = NO_CMD;
		r.want.fired         = fired;
		r.want.first_pattern = first_p;
		r.want.last_pattern  = last_p;
		r.want.start_time    = st;
		r.want.running       = run;
		return r;
	endfunction

	dir_row_t dir_rows[$];

	// ------------------------------------------------------------------
	// Receiver side: check each result beat and drive tready
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		start_cmd_t got;
		start_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = start_cmd_t'(m_tdata);
			if (expected_starts.size() == 0) begin
				report_mismatch("result beat with nothing expected", 0, 0);
			end else begin
				want = expected_starts.pop_front();
				if (got.fired !== want.fired)
					report_mismatch("fired", want.fired, got.fired);
				if (got.first_pattern !== want.first_pattern)
					report_mismatch("first_pattern", want.first_pattern, got.first_pattern);
				if (got.last_pattern !== want.last_pattern)
					report_mismatch("last_pattern", want.last_pattern, got.last_pattern);
				if (got.start_time !== want.start_time)
					report_mismatch("start_time", want.start_time, got.start_time);
				if (got.running !== want.running)
					report_mismatch("running", want.running, got.running);
			end
		end
		// long hold-off first, otherwise stall at the phase rate
		if (stall_hold > 0) begin
			m_tready <= 1'b0;
			stall_hold--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Abandon the run when neither side has moved a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		logic [15:0] seq_val;
		logic [15:0] cnt_val;
		beat_fields_t f;
		beat_fields_t noise;

		noise     = '1;
		noise.pad = '0;

		// After reset: steps while disabled, the ignored request code, then a
		// single-slot element with a zero pattern count and a zero repeat.
		dir_rows.push_back(row_chk(32'h0000_0000, 1'b0, 9'd0, 9'd0, 32'd0, 1'b0));
		dir_rows.push_back(row_beat(REQ_UNUSED, noise));
		dir_rows.push_back(row_chk(32'hFFFF_FFFF, 1'b0, 9'd0, 9'd0, 32'd0, 1'b0));
		dir_rows.push_back(row_load(7'd0, 3'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		dir_rows.push_back(row_reg(stsq_pkg::CFG_SEQUENCE_REPEATS, 16'd1));
		dir_rows.push_back(row_trig(1'b1));
		// top id, time stamp wraps to 99, then the single pass runs out
		dir_rows.push_back(row_chk(32'hFFFF_FFFF, 1'b1, 9'd508, 9'd509, 32'd99, 1'b1));
		dir_rows.push_back(row_chk(32'h0000_0000, 1'b0, 9'd0, 9'd0, 32'd0, 1'b0));
		dir_rows.push_back(row_chk(32'h0000_0005, 1'b0, 9'd0, 9'd0, 32'd0, 1'b0));
		// full element, saturating pattern count, top index, two-element walk
		dir_rows.push_back(row_load(7'd0, 3'd6, 8'd2, 8'd1, 8'd0, 8'd128, 8'd255, 8'd7, 8'd3));
		dir_rows.push_back(row_load(7'd127, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255));
		dir_rows.push_back(row_load(7'd1, 3'd2, 8'd1, 8'd0, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0));
		dir_rows.push_back(row_reg(stsq_pkg::CFG_SEQUENCE_REPEATS, 16'hFFFF));
		dir_rows.push_back(row_reg(stsq_pkg::CFG_ELEMENT_COUNT, 16'd2));
		dir_rows.push_back(row_trig(1'b1));
		dir_rows.push_back(row_step(32'h0000_0010));
		dir_rows.push_back(row_step(32'h8000_0000));
		dir_rows.push_back(row_step(32'h7FFF_FFFF));
		dir_rows.push_back(row_step(32'hFFFF_FF9B));
		dir_rows.push_back(row_step(32'hFFFF_FF9C));
		dir_rows.push_back(row_step(32'h1234_5678));
		dir_rows.push_back(row_step(32'hDEAD_BEEF));
		// zero repeats and a zero element count: disabled on the first step
		dir_rows.push_back(row_reg(stsq_pkg::CFG_ELEMENT_COUNT, 16'd0));
		dir_rows.push_back(row_reg(stsq_pkg::CFG_SEQUENCE_REPEATS, 16'd0));
		dir_rows.push_back(row_trig(1'b1));
		dir_rows.push_back(row_chk(32'h0000_0001, 1'b0, 9'd0, 9'd0, 32'd0, 1'b0));
		dir_rows.push_back(row_trig(1'b0));
		dir_rows.push_back(row_chk(32'hFFFF_FFFF, 1'b0, 9'd0, 9'd0, 32'd0, 1'b0));

		// hold reset, then release it once
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].reg_wr) begin
				drain_and_pause();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				offer_beat(dir_rows[i].req, dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Fill the whole table so no step can ever read an unwritten element.
		for (int e = 0; e < TBL_DEPTH; e++) begin
			f     = shape_element(rand_fields());
			f.idx = 7'(e);
			offer_beat(stsq_pkg::REQ_LOAD, f, 1'b0, NO_CMD);
		end

		// Four idling phases, two register settings each.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			for (int k = 0; k < 2; k++) begin
				case (2 * ph + k)
					0: begin seq_val = 16'hFFFF; cnt_val = 16'h00FF; end
					1: begin seq_val = 16'h0000; cnt_val = 16'h0000; end
					2: begin seq_val = 16'd1;    cnt_val = 16'd128;  end
					3: begin
						seq_val = 16'($urandom_range(1, 4));
						cnt_val = 16'($urandom_range(1, 8));
					end
					4: begin seq_val = 16'd2;    cnt_val = 16'd3;    end
					5: begin seq_val = 16'($urandom()); cnt_val = 16'($urandom()); end
					6: begin seq_val = 16'd3;    cnt_val = 16'd1;    end
					default: begin seq_val = 16'hFFFF; cnt_val = 16'd2; end
				endcase
				drain_and_pause();
				write_reg(stsq_pkg::CFG_SEQUENCE_REPEATS, seq_val);
				write_reg(stsq_pkg::CFG_ELEMENT_COUNT, cnt_val);
				if (ph == 0 && k == 0) begin
					// hold the receiver off and keep offering steps, so the block
					// fills up and stalls its input
					offer_beat(stsq_pkg::REQ_TRIGGER, '{enable: 1'b1, default: '0}, 1'b0,
						NO_CMD);
					stall_hold = HOLD_OFF_CYCLES;
					repeat (24) offer_beat(stsq_pkg::REQ_STEP, rand_fields(), 1'b0, NO_CMD);
				end
				run_random(110);
			end
		end

		// drain, let the pipe settle, then report
		drain_and_pause();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
